// ----- rtl/uer_pkg.sv -----
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

    // Tick counter width and the fixed conversion scale.
    localparam int TIMER_WIDTH = 16;
    localparam int SCALE_W     = 27;
    localparam logic [SCALE_W-1:0] SCALE_NUM = 27'd100000000;

    // Register field widths.
    localparam int TRIG_W = 8;
    localparam int EDIV_W = 16;
    localparam int CLK_W  = 26;
    localparam int MAXD_W = 15;
    localparam int DIST_W = 16;

    // Shared divider sizing: the widest dividend is the scaled quotient.
    localparam int DVD_W = TIMER_WIDTH + SCALE_W;
    localparam int DSR_W = CLK_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    // APB register map.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_TRIGGER_TICKS   = 2'd0,
        REG_ECHO_DIVISOR    = 2'd1,
        REG_CLOCK_HZ        = 2'd2,
        REG_MAX_DISTANCE_MM = 2'd3
    } cfg_reg_t;

    localparam logic [TRIG_W-1:0] TRIG_RESET = 8'd20;
    localparam logic [EDIV_W-1:0] EDIV_RESET = 16'd72;
    localparam logic [CLK_W-1:0]  CLK_RESET  = 26'd16000000;
    localparam logic [MAXD_W-1:0] MAXD_RESET = 15'd4000;

    // Input action codes.
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    // Measurement phase.
    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_TRIGGER   = 4'b0010,
        PH_WAIT_RISE = 4'b0100,
        PH_MEASURE   = 4'b1000
    } phase_t;

    // Sequencer of the shared divider.
    typedef enum logic [4:0] {
        SEQ_IDLE = 5'b00001,
        SEQ_DIV1 = 5'b00010,
        SEQ_MUL  = 5'b00100,
        SEQ_DIV2 = 5'b01000,
        SEQ_FIN  = 5'b10000
    } seq_t;

endpackage

// ----- rtl/ultrasonic_echo_ranger_unit.sv -----
// Ultrasonic echo ranger: trigger/echo phase tracking and distance conversion.
//
// Usage: every input word is either one prescaled timer tick (s_action low)
// carrying the sampled echo pin level, or a start request (s_action high).
// Every accepted word yields exactly one result word on the m_ channel with
// the trigger pin level, the busy flag, whether a start was taken, whether a
// measurement finished, and the last distance in millimeters (-1 for no echo
// within range or a counter wrap).
// Throughput: a word that does not end a measurement with an echo fall is
// answered in the result register in the cycle after acceptance, and such
// words can be taken every cycle while the receiver keeps up and the divider is free.
// A word on which the echo falls starts the distance conversion on a shared
// restoring divider, one quotient bit per cycle: the tick divide, the scale
// multiply, the clock divide and the range compare follow in that order
// before the result word appears; s_ready stays low meanwhile.
// Reset (aresetn low at a clock edge) returns the registers to their default
// values, the phase to idle and the stored distance to zero, and empties the
// result register. When the receiver stalls, the result word is held and no
// new input word is taken until the register is free or being emptied.
// Configuration goes through the APB port; pready is always high.
module ultrasonic_echo_ranger_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic                          s_echo_level,
    // Result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_trigger_level,
    output logic                          m_busy_res,
    output logic                          m_start_accepted,
    output logic                          m_done_res,
    output logic signed [uer_pkg::DIST_W-1:0] m_distance_mm,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [uer_pkg::PADDR_W-1:0]   paddr,
    input  logic [uer_pkg::PDATA_W-1:0]   pwdata,
    output logic [uer_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import uer_pkg::*;

    // Configuration registers.
    logic [TRIG_W-1:0] trig_ticks_reg;
    logic [EDIV_W-1:0] echo_div_reg;
    logic [CLK_W-1:0]  clock_hz_reg;
    logic [MAXD_W-1:0] max_dist_reg;

    // Measurement state.
    phase_t                 phase_reg, phase_next;
    logic [TRIG_W-1:0]      trig_cnt_reg, trig_cnt_next;
    logic [TIMER_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [DIST_W-1:0]      last_dist_reg, last_dist_next;

    // Shared divider and its sequencer.
    seq_t             seq_reg, seq_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Result register.
    logic              m_valid_reg, m_valid_next;
    logic              out_trig_reg, out_trig_next;
    logic              out_busy_reg, out_busy_next;
    logic              out_acc_reg, out_acc_next;
    logic              out_done_reg, out_done_next;
    logic [DIST_W-1:0] out_dist_reg, out_dist_next;

    logic             in_fire;
    logic             cfg_write;
    logic [DSR_W:0]   rem_shift;
    logic             rem_ge;
    logic [DSR_W-1:0] rem_sub;
    logic [EDIV_W-1:0] echo_div_eff;
    logic [CLK_W-1:0]  clock_hz_eff;
    logic             start_acc;
    logic             meas_done;
    logic             convert;
    logic             over_range;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_ticks_reg <= TRIG_RESET;
            echo_div_reg   <= EDIV_RESET;
            clock_hz_reg   <= CLK_RESET;
            max_dist_reg   <= MAXD_RESET;
        end else if (cfg_write) begin
            unique case (cfg_reg_t'(paddr[3:2]))
                REG_TRIGGER_TICKS:   trig_ticks_reg <= pwdata[TRIG_W-1:0];
                REG_ECHO_DIVISOR:    echo_div_reg   <= pwdata[EDIV_W-1:0];
                REG_CLOCK_HZ:        clock_hz_reg   <= pwdata[CLK_W-1:0];
                REG_MAX_DISTANCE_MM: max_dist_reg   <= pwdata[MAXD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_reg_t'(paddr[3:2]))
            REG_TRIGGER_TICKS:   prdata = PDATA_W'(trig_ticks_reg);
            REG_ECHO_DIVISOR:    prdata = PDATA_W'(echo_div_reg);
            REG_CLOCK_HZ:        prdata = PDATA_W'(clock_hz_reg);
            REG_MAX_DISTANCE_MM: prdata = PDATA_W'(max_dist_reg);
            default:             prdata = '0;
        endcase
    end

    // A zero divisor behaves as one.
    assign echo_div_eff = (echo_div_reg == '0) ? EDIV_W'(1) : echo_div_reg;
    assign clock_hz_eff = (clock_hz_reg == '0) ? CLK_W'(1) : clock_hz_reg;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    // Words are taken only while the divider is free and the result register
    // is empty or being emptied in this cycle.
    assign s_ready = (seq_reg == SEQ_IDLE) && (!m_valid_reg || m_ready);
    assign in_fire = s_valid && s_ready;

    assign m_valid          = m_valid_reg;
    assign m_trigger_level  = out_trig_reg;
    assign m_busy_res       = out_busy_reg;
    assign m_start_accepted = out_acc_reg;
    assign m_done_res       = out_done_reg;
    assign m_distance_mm    = out_dist_reg;

    // ------------------------------------------------------------------
    // Restoring divide step: one quotient bit per cycle. The quotient bits
    // shift into the low end of the dividend register.
    // ------------------------------------------------------------------
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dsr_reg});
    assign rem_sub   = DSR_W'(rem_shift - {1'b0, dsr_reg});

    // The converted value is below 2^15 whenever it is in range.
    assign over_range = (dvd_reg > DVD_W'(max_dist_reg));

    // ------------------------------------------------------------------
    // Phase tracking and sequencer
    // ------------------------------------------------------------------
    always_comb begin
        phase_next     = phase_reg;
        trig_cnt_next  = trig_cnt_reg;
        elapsed_next   = elapsed_reg;
        last_dist_next = last_dist_reg;
        seq_next       = seq_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg;
        out_trig_next  = out_trig_reg;
        out_busy_next  = out_busy_reg;
        out_acc_next   = out_acc_reg;
        out_done_next  = out_done_reg;
        out_dist_next  = out_dist_reg;
        start_acc      = 1'b0;
        meas_done      = 1'b0;
        convert        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (seq_reg) inside
            SEQ_IDLE: begin
                if (in_fire) begin
                    if (s_action == ACT_START) begin
                        // A start is refused unless the block is idle.
                        if (phase_reg == PH_IDLE) begin
                            start_acc     = 1'b1;
                            phase_next    = PH_TRIGGER;
                            trig_cnt_next = trig_ticks_reg;
                            elapsed_next  = '0;
                        end
                    end else begin
                        unique case (phase_reg)
                            PH_TRIGGER: begin
                                // A pulse length of zero still gives one tick.
                                if (trig_cnt_reg <= TRIG_W'(1)) begin
                                    trig_cnt_next = '0;
                                    phase_next    = PH_WAIT_RISE;
                                end else begin
                                    trig_cnt_next = trig_cnt_reg - TRIG_W'(1);
                                end
                            end
                            PH_WAIT_RISE: begin
                                if (s_echo_level) begin
                                    elapsed_next = '0;
                                    phase_next   = PH_MEASURE;
                                end
                            end
                            PH_MEASURE: begin
                                if (s_echo_level) begin
                                    if (elapsed_reg == '1) begin
                                        elapsed_next   = '0;
                                        last_dist_next = '1;
                                        phase_next     = PH_IDLE;
                                        meas_done      = 1'b1;
                                    end else begin
                                        elapsed_next = elapsed_reg + TIMER_WIDTH'(1);
                                    end
                                end else begin
                                    convert    = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                            end
                            default: ;
                        endcase
                    end

                    if (convert) begin
                        // Tick count goes in left-aligned for the first divide.
                        seq_next = SEQ_DIV1;
                        dvd_next = {elapsed_reg, {(DVD_W - TIMER_WIDTH){1'b0}}};
                        rem_next = '0;
                        dsr_next = DSR_W'(echo_div_eff);
                        cnt_next = CNT_W'(TIMER_WIDTH);
                    end else begin
                        m_valid_next  = 1'b1;
                        out_trig_next = (phase_next == PH_TRIGGER);
                        out_busy_next = (phase_next != PH_IDLE);
                        out_acc_next  = start_acc;
                        out_done_next = meas_done;
                        out_dist_next = last_dist_next;
                    end
                end
            end
            SEQ_DIV1, SEQ_DIV2: begin
                dvd_next = {dvd_reg[DVD_W-2:0], rem_ge};
                rem_next = rem_ge ? rem_sub : rem_shift[DSR_W-1:0];
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    seq_next = (seq_reg == SEQ_DIV1) ? SEQ_MUL : SEQ_FIN;
                end
            end
            SEQ_MUL: begin
                // Scale the tick quotient, then divide by the clock rate.
                dvd_next = DVD_W'(dvd_reg[TIMER_WIDTH-1:0] * SCALE_NUM);
                rem_next = '0;
                dsr_next = clock_hz_eff;
                cnt_next = CNT_W'(DVD_W);
                seq_next = SEQ_DIV2;
            end
            SEQ_FIN: begin
                last_dist_next = over_range ? '1 : dvd_reg[DIST_W-1:0];
                seq_next       = SEQ_IDLE;
                m_valid_next   = 1'b1;
                out_trig_next  = 1'b0;
                out_busy_next  = 1'b0;
                out_acc_next   = 1'b0;
                out_done_next  = 1'b1;
                out_dist_next  = over_range ? '1 : dvd_reg[DIST_W-1:0];
            end
            default: seq_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            trig_cnt_reg  <= '0;
            elapsed_reg   <= '0;
            last_dist_reg <= '0;
            seq_reg       <= SEQ_IDLE;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            trig_cnt_reg  <= trig_cnt_next;
            elapsed_reg   <= elapsed_next;
            last_dist_reg <= last_dist_next;
            seq_reg       <= seq_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        cnt_reg      <= cnt_next;
        out_trig_reg <= out_trig_next;
        out_busy_reg <= out_busy_next;
        out_acc_reg  <= out_acc_next;
        out_done_reg <= out_done_next;
        out_dist_reg <= out_dist_next;
    end

endmodule

// ----- rtl/uer_checker.sv -----
// Port-level checker for the ultrasonic echo ranger and its bind statement.
module uer_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_trigger_level,
    input logic                          m_busy_res,
    input logic                          m_start_accepted,
    input logic                          m_done_res,
    input logic [uer_pkg::DIST_W-1:0]    m_distance_mm
);
    import uer_pkg::*;

    // A finished measurement leaves the block idle.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> (!m_busy_res && !m_trigger_level))
        else $error("done word reports busy or trigger");

    // A taken start always begins with the trigger pulse.
    a_start_triggers: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_start_accepted) |-> (m_trigger_level && m_busy_res && !m_done_res))
        else $error("accepted start without trigger");

    // The trigger is only driven during a measurement.
    a_trigger_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_trigger_level) |-> m_busy_res)
        else $error("trigger high while idle");

    // A stalled result word holds.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_distance_mm)
            && $stable(m_done_res)))
        else $error("result word changed under stall");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_trigger_level  (m_trigger_level),
    .m_busy_res       (m_busy_res),
    .m_start_accepted (m_start_accepted),
    .m_done_res       (m_done_res),
    .m_distance_mm    (m_distance_mm)
);
